@@ src/ptci_pkg.sv @@
// ptci_pkg: shared constants, register codes and structs for the
// position_to_cell_index block. No dependencies.
`timescale 1ns / 1ps

package ptci_pkg;

   localparam int GRID_BITS    = 6;
   localparam int IDX_BITS     = 3 * GRID_BITS;
   localparam int COORD_BITS   = GRID_BITS + 1;
   localparam int POS_BITS     = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int NUM_AXES     = 3;
   localparam int PIPE_STAGES  = 5;

   localparam logic [GRID_BITS-1:0]  DIM_RESET = GRID_BITS'(1);
   localparam logic [POS_BITS-1:0]   INV_RESET = POS_BITS'(65536);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LEFT_X,
      CSR_LEFT_Y,
      CSR_LEFT_Z,
      CSR_INV_SIZE_X,
      CSR_INV_SIZE_Y,
      CSR_INV_SIZE_Z,
      CSR_GRID_DIMS
   } csr_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0]  left;
      logic [POS_BITS-1:0]  inv;
      logic [GRID_BITS-1:0] n;
   } axis_cfg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] coord;
      logic                  flag;
   } coord_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] cell_index;
      logic                out_of_range;
   } result_type;

endpackage

@@ src/ptci_axis_lane.sv @@
// ptci_axis_lane: one axis of the binning pipeline (subtract, multiply,
// truncate and limit). Three stages. Depends on ptci_pkg.
`timescale 1ns / 1ps

module ptci_axis_lane import ptci_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [POS_BITS-1:0] pos,
   input  logic                clamp,
   input  axis_cfg_type        cfg,
   output coord_type           result
);

   logic [POS_BITS:0]       diff;
   logic [POS_BITS:0]       diff_neg;
   logic [2*POS_BITS-1:0]   prod;

   logic [POS_BITS-1:0]     mag_ff, mag_in;
   logic                    neg_a_ff, neg_a_in;
   logic                    clamp_a_ff;

   logic [POS_BITS-1:0]     q_ff, q_in;
   logic                    neg_b_ff;
   logic                    clamp_b_ff;

   coord_type               res_ff, res_in;

   logic [GRID_BITS-1:0]    q_small;
   logic [COORD_BITS-1:0]   q_inc;
   logic [COORD_BITS-1:0]   n_ext;
   logic                    q_gt_n;
   logic                    q_ge_n;

   // stage a: exact difference and its magnitude
   always_comb begin
      diff     = {pos[POS_BITS-1], pos} - {cfg.left[POS_BITS-1], cfg.left};
      diff_neg = '0 - diff;
      neg_a_in = diff[POS_BITS];
      mag_in   = neg_a_in ? diff_neg[POS_BITS-1:0] : diff[POS_BITS-1:0];
   end

   // stage b: scale by inverse cell size, keep integer part of Q32.32
   always_comb begin
      prod = {{POS_BITS{1'b0}}, mag_ff} * {{POS_BITS{1'b0}}, cfg.inv};
      q_in = prod[2*POS_BITS-1:POS_BITS];
   end

   // stage c: ghost offset, clamp or saturate
   always_comb begin
      q_small = q_ff[GRID_BITS-1:0];
      q_inc   = {1'b0, q_small} + COORD_BITS'(1);
      n_ext   = {1'b0, cfg.n};
      q_gt_n  = q_ff > POS_BITS'(cfg.n);
      q_ge_n  = q_ff >= POS_BITS'(cfg.n);
      if (neg_b_ff) begin
         // coordinate is 1 - q here
         res_in.flag  = !clamp_b_ff && (q_ff > POS_BITS'(1));
         res_in.coord = (clamp_b_ff || q_ff == '0) ? COORD_BITS'(1) : '0;
      end else if (clamp_b_ff) begin
         res_in.flag  = 1'b0;
         if (q_ge_n) begin
            res_in.coord = (cfg.n == '0) ? COORD_BITS'(1) : n_ext;
         end else begin
            res_in.coord = q_inc;
         end
      end else begin
         res_in.flag  = q_gt_n;
         res_in.coord = q_gt_n ? n_ext + COORD_BITS'(1) : q_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff     <= mag_in;
         neg_a_ff   <= neg_a_in;
         clamp_a_ff <= clamp;
         q_ff       <= q_in;
         neg_b_ff   <= neg_a_ff;
         clamp_b_ff <= clamp_a_ff;
         res_ff     <= res_in;
      end
   end

   assign result = res_ff;

endmodule

@@ src/ptci_merge.sv @@
// ptci_merge: combines the three axis coordinates into the linear
// ghost-grid index, x fastest. Two stages. Depends on ptci_pkg.
`timescale 1ns / 1ps

module ptci_merge import ptci_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  coord_type            coord_x,
   input  coord_type            coord_y,
   input  coord_type            coord_z,
   input  logic [GRID_BITS-1:0] n_x,
   input  logic [GRID_BITS-1:0] n_y,
   output result_type           result
);

   localparam int YZ_BITS   = 2 * COORD_BITS + 1;
   localparam int FULL_BITS = 3 * COORD_BITS + 1;

   logic [COORD_BITS-1:0]  gx;
   logic [COORD_BITS-1:0]  gy;
   logic [FULL_BITS-1:0]   idx_full;

   logic [YZ_BITS-1:0]     yz_ff, yz_in;
   logic [COORD_BITS-1:0]  cx_ff;
   logic                   flag_ff, flag_in;
   result_type             res_ff, res_in;

   // stage d: cy + gy * cz
   always_comb begin
      gy      = {1'b0, n_y} + COORD_BITS'(2);
      yz_in   = YZ_BITS'(coord_y.coord) + YZ_BITS'(gy) * YZ_BITS'(coord_z.coord);
      flag_in = coord_x.flag | coord_y.flag | coord_z.flag;
   end

   // stage e: cx + gx * (...), wraps to the index width
   always_comb begin
      gx       = {1'b0, n_x} + COORD_BITS'(2);
      idx_full = FULL_BITS'(cx_ff) + FULL_BITS'(gx) * FULL_BITS'(yz_ff);
      res_in.cell_index   = idx_full[IDX_BITS-1:0];
      res_in.out_of_range = flag_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yz_ff   <= yz_in;
         cx_ff   <= coord_x.coord;
         flag_ff <= flag_in;
         res_ff  <= res_in;
      end
   end

   assign result = res_ff;

endmodule

@@ src/ptci_out_buf.sv @@
// ptci_out_buf: output register plus one skid entry, so the pipeline
// only sees a registered ready. Depends on ptci_pkg.
`timescale 1ns / 1ps

module ptci_out_buf import ptci_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_full_ff, skid_full_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;

   always_comb begin
      take         = in_valid && !skid_full_ff;
      out_valid_in = out_valid_ff;
      skid_full_in = skid_full_ff;
      out_data_in  = out_data_ff;
      skid_data_in = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_full_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = skid_data_ff;
            skid_full_in = 1'b0;
         end else if (take) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (take) begin
         skid_full_in = 1'b1;
         skid_data_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_full_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ src/position_to_cell_index.sv @@
// position_to_cell_index: top level of the cell binning block, with the
// register file, three axis lanes, the index merge and the output buffer.
// Depends on ptci_pkg, ptci_axis_lane, ptci_merge, ptci_out_buf.
//
//   channel   prefix  direction  transaction
//   ---------------------------------------------------------------
//   request   req_    in         pos_x, pos_y, pos_z, clamp
//   response  rsp_    out        cell_index, out_of_range
//   csr       csr_    in         index, data (always ready)
//
// One transaction per cycle sustained while rsp_ready stays high; a taken request
// passes the three lane stages, the two merge stages and the output register
// before rsp_valid rises.
// The 32x32 multiply in each lane sets the stage depth.
// Reset is synchronous; it clears valids and loads register defaults.
// A stalled response fills the skid entry, then the whole pipeline holds.
`timescale 1ns / 1ps

module position_to_cell_index import ptci_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   input  logic signed [POS_BITS-1:0] req_pos_z,
   input  logic                     req_clamp,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_BITS-1:0]      rsp_cell_index,
   output logic                     rsp_out_of_range,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic [POS_BITS-1:0]    left_ff [NUM_AXES];
   logic [POS_BITS-1:0]    inv_ff  [NUM_AXES];
   logic [IDX_BITS-1:0]    dims_ff;

   logic [PIPE_STAGES-1:0] vld_ff;
   logic                   en;
   logic                   accept;

   logic [POS_BITS-1:0]    pos_arr [NUM_AXES];
   axis_cfg_type           cfg_arr [NUM_AXES];
   coord_type              coord_arr [NUM_AXES];
   result_type             merged;
   result_type             rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            left_ff[i] <= '0;
            inv_ff[i]  <= INV_RESET;
         end
         dims_ff <= {DIM_RESET, DIM_RESET, DIM_RESET};
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LEFT_X:     left_ff[0] <= csr_data;
            CSR_LEFT_Y:     left_ff[1] <= csr_data;
            CSR_LEFT_Z:     left_ff[2] <= csr_data;
            CSR_INV_SIZE_X: inv_ff[0]  <= csr_data;
            CSR_INV_SIZE_Y: inv_ff[1]  <= csr_data;
            CSR_INV_SIZE_Z: inv_ff[2]  <= csr_data;
            CSR_GRID_DIMS:  dims_ff    <= csr_data[IDX_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline moves as a unit while the skid entry is free
   assign req_ready = en;
   assign accept    = req_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], accept};
      end
   end

   assign pos_arr[0] = req_pos_x;
   assign pos_arr[1] = req_pos_y;
   assign pos_arr[2] = req_pos_z;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      always_comb begin
         cfg_arr[a].left = left_ff[a];
         cfg_arr[a].inv  = inv_ff[a];
         cfg_arr[a].n    = dims_ff[a*GRID_BITS +: GRID_BITS];
      end

      ptci_axis_lane u_lane (
         .clock  (clock),
         .en     (en),
         .pos    (pos_arr[a]),
         .clamp  (req_clamp),
         .cfg    (cfg_arr[a]),
         .result (coord_arr[a])
      );
   end

   ptci_merge u_merge (
      .clock   (clock),
      .en      (en),
      .coord_x (coord_arr[0]),
      .coord_y (coord_arr[1]),
      .coord_z (coord_arr[2]),
      .n_x     (cfg_arr[0].n),
      .n_y     (cfg_arr[1].n),
      .result  (merged)
   );

   ptci_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[PIPE_STAGES-1]),
      .in_ready  (en),
      .in_data   (merged),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_cell_index   = rsp_data.cell_index;
   assign rsp_out_of_range = rsp_data.out_of_range;

endmodule
